[sv/bje_pkg.sv]
// Shared types, widths and the per-bin constant table for the binned jet resolution block.
// No dependencies; every other file of the block imports this package.
package bje_pkg;

  // Field widths
  localparam int ETA_W = 14;
  localparam int ET_W  = 20;
  localparam int RES_W = 20;
  localparam int MAG_W = 14;

  // Table layout
  localparam int ROM_BINS = 26;
  localparam int BIN_W    = 5;
  localparam int HI_W     = 12;
  localparam int A_W      = 10;
  localparam int B2_W     = 14;
  localparam int C2_W     = 16;
  localparam int K_W      = 19;

  // Datapath widths
  localparam int AE_W     = A_W + ET_W;     // a*E
  localparam int BE_W     = B2_W + ET_W;    // b^2*E
  localparam int BT_W     = BE_W + 20;      // 1e6*b^2*E
  localparam int CT_W     = C2_W + 27;      // 1e8*c^2
  localparam int R_W      = 2 * AE_W;       // radicand
  localparam int S_W      = R_W / 2;        // root
  localparam int REM_W    = S_W + 2;        // root remainder
  localparam int P_W      = S_W + K_W;      // root * cosh
  localparam int RND_SH   = 20;             // 655360000 = 2^20 * 625
  localparam int Q_W      = P_W - RND_SH;
  localparam int RECIP_W  = 30;
  localparam int RECIP_SH = 39;
  localparam int PROD_W   = Q_W + RECIP_W;

  localparam logic [19:0]        B_SCALE     = 20'd1000000;
  localparam logic [26:0]        C_SCALE     = 27'd100000000;
  localparam logic [28:0]        ROUND_HALF  = 29'd327680000;
  // ceil(2^39 / 625): exact floor division for quotients below 2^29
  localparam logic [RECIP_W-1:0] RECIP       = 30'd879609303;
  localparam logic [RES_W-1:0]   DEFAULT_RES = 20'd1000;

  // One bin: upper |eta| edge (milli, exclusive), a (1e-4), b^2 and c^2 (0.01^2), cosh (Q16)
  typedef struct packed {
    logic [HI_W-1:0] hi;
    logic [A_W-1:0]  a;
    logic [B2_W-1:0] b2;
    logic [C2_W-1:0] c2;
    logic [K_W-1:0]  k;
  } bin_rom_t;

  // Sideband carried along the arithmetic pipeline
  typedef struct packed {
    logic           in_range;
    logic [K_W-1:0] k;
  } side_t;

  function automatic bin_rom_t bin_rom(input logic [BIN_W-1:0] idx);
    bin_rom_t ent;
    case (idx)
      5'd0:    ent = '{hi: 12'd87,   a: 10'd686, b2: 14'd10609, c2: 16'd28224, k: 19'd65598};
      5'd1:    ent = '{hi: 12'd174,  a: 10'd737, b2: 14'd10201, c2: 16'd30276, k: 19'd66095};
      5'd2:    ent = '{hi: 12'd261,  a: 10'd657, b2: 14'd11449, c2: 16'd0,     k: 19'd67092};
      5'd3:    ent = '{hi: 12'd348,  a: 10'd620, b2: 14'd11449, c2: 16'd0,     k: 19'd68598};
      5'd4:    ent = '{hi: 12'd435,  a: 10'd605, b2: 14'd11449, c2: 16'd0,     k: 19'd70623};
      5'd5:    ent = '{hi: 12'd522,  a: 10'd590, b2: 14'd11664, c2: 16'd0,     k: 19'd73183};
      5'd6:    ent = '{hi: 12'd609,  a: 10'd577, b2: 14'd11664, c2: 16'd0,     k: 19'd76297};
      5'd7:    ent = '{hi: 12'd696,  a: 10'd525, b2: 14'd11881, c2: 16'd0,     k: 19'd79989};
      5'd8:    ent = '{hi: 12'd783,  a: 10'd582, b2: 14'd11881, c2: 16'd0,     k: 19'd84287};
      5'd9:    ent = '{hi: 12'd870,  a: 10'd649, b2: 14'd11664, c2: 16'd0,     k: 19'd89223};
      5'd10:   ent = '{hi: 12'd957,  a: 10'd654, b2: 14'd12100, c2: 16'd0,     k: 19'd94836};
      5'd11:   ent = '{hi: 12'd1044, a: 10'd669, b2: 14'd12321, c2: 16'd0,     k: 19'd101166};
      5'd12:   ent = '{hi: 12'd1131, a: 10'd643, b2: 14'd13225, c2: 16'd0,     k: 19'd108262};
      5'd13:   ent = '{hi: 12'd1218, a: 10'd645, b2: 14'd13456, c2: 16'd0,     k: 19'd116179};
      5'd14:   ent = '{hi: 12'd1305, a: 10'd637, b2: 14'd14161, c2: 16'd0,     k: 19'd124975};
      5'd15:   ent = '{hi: 12'd1392, a: 10'd695, b2: 14'd14641, c2: 16'd0,     k: 19'd134718};
      5'd16:   ent = '{hi: 12'd1479, a: 10'd748, b2: 14'd14400, c2: 16'd0,     k: 19'd145481};
      5'd17:   ent = '{hi: 12'd1566, a: 10'd624, b2: 14'd15129, c2: 16'd0,     k: 19'd157347};
      5'd18:   ent = '{hi: 12'd1653, a: 10'd283, b2: 14'd15625, c2: 16'd0,     k: 19'd170403};
      5'd19:   ent = '{hi: 12'd1740, a: 10'd316, b2: 14'd14641, c2: 16'd0,     k: 19'd184751};
      5'd20:   ent = '{hi: 12'd1830, a: 10'd0,   b2: 14'd14400, c2: 16'd0,     k: 19'd200782};
      5'd21:   ent = '{hi: 12'd1930, a: 10'd0,   b2: 14'd12996, c2: 16'd28900, k: 19'd219745};
      5'd22:   ent = '{hi: 12'd2043, a: 10'd0,   b2: 14'd11881, c2: 16'd43264, k: 19'd243373};
      5'd23:   ent = '{hi: 12'd2172, a: 10'd0,   b2: 14'd11881, c2: 16'd26569, k: 19'd273586};
      5'd24:   ent = '{hi: 12'd2322, a: 10'd0,   b2: 14'd11881, c2: 16'd28224, k: 19'd313427};
      5'd25:   ent = '{hi: 12'd2500, a: 10'd0,   b2: 14'd12544, c2: 16'd31684, k: 19'd368143};
      default: ent = '0;
    endcase
    return ent;
  endfunction

endpackage

[sv/bje_lookup.sv]
// Input stage: |eta|, bin search over the table and fetch of the bin's constants.
// Depends on bje_pkg.
module bje_lookup #(
  parameter int NUM_BINS = 26
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [bje_pkg::ETA_W-1:0]   eta,
  input  logic [bje_pkg::ET_W-1:0]    et,
  output logic                        out_v,
  output logic [bje_pkg::ET_W-1:0]    out_e,
  output logic [bje_pkg::A_W-1:0]     out_a,
  output logic [bje_pkg::B2_W-1:0]    out_b2,
  output logic [bje_pkg::C2_W-1:0]    out_c2,
  output bje_pkg::side_t              out_side
);
  import bje_pkg::*;

  localparam int NBINS = (NUM_BINS < ROM_BINS) ? NUM_BINS : ROM_BINS;

  logic [MAG_W-1:0] mag;
  logic             found;
  logic [BIN_W-1:0] idx;
  bin_rom_t         cand;
  bin_rom_t         ent;

  logic             v_r;
  logic [ET_W-1:0]  e_r;
  logic [A_W-1:0]   a_r;
  logic [B2_W-1:0]  b2_r;
  logic [C2_W-1:0]  c2_r;
  side_t            side_r;

  // Magnitude; the most negative code maps to 8192
  assign mag = eta[ETA_W-1] ? MAG_W'(~eta + 1'b1) : MAG_W'(eta);

  // Edges rise, so the lowest matching bin wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    cand  = '0;
    for (int i = ROM_BINS - 1; i >= 0; i--) begin
      cand = bin_rom(BIN_W'(i));
      if (i < NBINS && mag < MAG_W'(cand.hi)) begin
        found = 1'b1;
        idx   = BIN_W'(i);
      end
    end
    ent = bin_rom(idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r             <= et;
      a_r             <= ent.a;
      b2_r            <= ent.b2;
      c2_r            <= ent.c2;
      side_r.in_range <= found;
      side_r.k        <= ent.k;
    end
  end

  assign out_v    = v_r;
  assign out_e    = e_r;
  assign out_a    = a_r;
  assign out_b2   = b2_r;
  assign out_c2   = c2_r;
  assign out_side = side_r;

endmodule

[sv/bje_terms.sv]
// Radicand pipeline: (a*E)^2 + 1e6*b^2*E + 1e8*c^2 over three register stages.
// Depends on bje_pkg.
module bje_terms (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [bje_pkg::ET_W-1:0]  e,
  input  logic [bje_pkg::A_W-1:0]   a,
  input  logic [bje_pkg::B2_W-1:0]  b2,
  input  logic [bje_pkg::C2_W-1:0]  c2,
  input  bje_pkg::side_t            in_side,
  output logic                      out_v,
  output logic [bje_pkg::R_W-1:0]   r,
  output bje_pkg::side_t            out_side
);
  import bje_pkg::*;

  logic [AE_W-1:0] ae_nxt;
  logic [BE_W-1:0] be_nxt;
  logic [R_W-1:0]  ae2_nxt;
  logic [BT_W-1:0] bt_nxt;
  logic [CT_W-1:0] ct_nxt;
  logic [R_W-1:0]  r_nxt;

  logic            v1_r, v2_r, v3_r;
  logic [AE_W-1:0] ae_r;
  logic [BE_W-1:0] be_r;
  logic [C2_W-1:0] c2_r;
  side_t           side1_r, side2_r, side3_r;
  logic [R_W-1:0]  ae2_r;
  logic [BT_W-1:0] bt_r;
  logic [CT_W-1:0] ct_r;
  logic [R_W-1:0]  r_r;

  // Stage 1: products with E; stage 2: square and constant scaling; stage 3: sum
  always_comb begin
    ae_nxt  = AE_W'(a) * AE_W'(e);
    be_nxt  = BE_W'(b2) * BE_W'(e);
    ae2_nxt = R_W'(ae_r) * R_W'(ae_r);
    bt_nxt  = BT_W'(be_r) * BT_W'(B_SCALE);
    ct_nxt  = CT_W'(c2_r) * CT_W'(C_SCALE);
    r_nxt   = ae2_r + R_W'(bt_r) + R_W'(ct_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ae_r    <= ae_nxt;
      be_r    <= be_nxt;
      c2_r    <= c2;
      side1_r <= in_side;
      ae2_r   <= ae2_nxt;
      bt_r    <= bt_nxt;
      ct_r    <= ct_nxt;
      side2_r <= side1_r;
      r_r     <= r_nxt;
      side3_r <= side2_r;
    end
  end

  assign out_v    = v3_r;
  assign r        = r_r;
  assign out_side = side3_r;

endmodule

[sv/bje_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on bje_pkg.
module bje_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [bje_pkg::R_W-1:0]   in_r,
  input  bje_pkg::side_t            in_side,
  output logic                      out_v,
  output logic [bje_pkg::S_W-1:0]   s,
  output bje_pkg::side_t            out_side
);
  import bje_pkg::*;

  logic             v_r    [S_W];
  logic [REM_W-1:0] rem_r  [S_W];
  logic [S_W-1:0]   root_r [S_W];
  logic [R_W-1:0]   x_r    [S_W];
  side_t            side_r [S_W];

  for (genvar g = 0; g < S_W; g++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [S_W-1:0]   root_in;
    logic [R_W-1:0]   x_in;
    side_t            side_in;
    logic [REM_W+1:0] sh, trial, diff;
    logic [REM_W-1:0] rem_nxt;
    logic [S_W-1:0]   root_nxt;
    logic [R_W-1:0]   x_nxt;

    if (g == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_r;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign x_in    = x_r[g-1];
      assign side_in = side_r[g-1];
    end

    // Bring down two radicand bits, try 4*root+1
    always_comb begin
      sh    = {rem_in, x_in[R_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      diff  = sh - trial;
      x_nxt = {x_in[R_W-3:0], 2'b00};
      if (sh >= trial) begin
        rem_nxt  = diff[REM_W-1:0];
        root_nxt = {root_in[S_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sh[REM_W-1:0];
        root_nxt = {root_in[S_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        x_r[g]    <= x_nxt;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_v    = v_r[S_W-1];
  assign s        = root_r[S_W-1];
  assign out_side = side_r[S_W-1];

endmodule

[sv/bje_scale.sv]
// Output arithmetic: root times cosh(centre), rounded division by 1e4*2^16, default select.
// Depends on bje_pkg.
module bje_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [bje_pkg::S_W-1:0]    s,
  input  bje_pkg::side_t             in_side,
  output logic                       out_v,
  output logic [bje_pkg::RES_W-1:0]  res,
  output logic                       in_range
);
  import bje_pkg::*;

  logic [P_W-1:0]    p_nxt;
  logic [P_W-1:0]    rsum;
  logic [Q_W-1:0]    q;
  logic [PROD_W-1:0] prod_nxt;
  logic [RES_W-1:0]  quo;
  logic [RES_W-1:0]  res_nxt;

  logic              v1_r, v2_r, v3_r;
  logic [P_W-1:0]    p_r;
  logic [PROD_W-1:0] prod_r;
  logic              fl1_r, fl2_r, fl3_r;
  logic [RES_W-1:0]  res_r;

  // Divide by 2^20 * 625: add half, shift, then reciprocal multiply for /625.
  // The quotient stays below 2^20 for every bin, so it never needs to clip.
  always_comb begin
    p_nxt    = P_W'(s) * P_W'(in_side.k);
    rsum     = p_r + P_W'(ROUND_HALF);
    q        = rsum[P_W-1:RND_SH];
    prod_nxt = PROD_W'(q) * PROD_W'(RECIP);
    quo      = prod_r[PROD_W-1:RECIP_SH];
    res_nxt  = fl2_r ? quo : DEFAULT_RES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      fl1_r  <= in_side.in_range;
      prod_r <= prod_nxt;
      fl2_r  <= fl1_r;
      res_r  <= res_nxt;
      fl3_r  <= fl2_r;
    end
  end

  assign out_v    = v3_r;
  assign res      = res_r;
  assign in_range = fl3_r;

endmodule

[sv/binned_jet_energy_resolution.sv]
// Top level of the binned jet energy resolution block: pipeline chain and output skid register.
// Depends on bje_pkg, bje_lookup, bje_terms, bje_sqrt and bje_scale.
//
// Usage:
//   The in_ channel takes one jet per request: in_tdata holds eta in milli units
//   (signed) and E_T in 0.01 GeV. The out_ channel returns one result per jet,
//   in order: the resolution in 0.01 GeV on out_tdata and the in-bin flag on
//   out_tuser. A jet with |eta| at or above the last searched edge gets 10 GeV
//   and flag 0.
//   Throughput is one jet per clock while the receiver does not stall. Each
//   jet passes in order through the bin search register, the radicand stages,
//   the square-root stages (one root bit per stage) and the scaling and
//   rounding stages; the last of these drives out_tvalid and out_tdata.
//   When the receiver stalls, the finished result moves into a skid register
//   and the pipeline freezes in the cycle after via in_tready; nothing is dropped
//   or repeated, and in_tready depends only on registered state.
//   Synchronous active-low reset clears all valid bits, the skid register's included;
//   the block holds no other control state and can take a request right after reset.
module binned_jet_energy_resolution #(
  parameter int NUM_BINS = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [13:0] eta_milli, [33:14] et_centi_gev, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] resolution_centi_gev, rest zero
  output logic [0:0]  out_tuser   // [0] in_bin_range
);
  import bje_pkg::*;

  logic              en;
  logic              lk_v;
  logic [ET_W-1:0]   lk_e;
  logic [A_W-1:0]    lk_a;
  logic [B2_W-1:0]   lk_b2;
  logic [C2_W-1:0]   lk_c2;
  side_t             lk_side;
  logic              tm_v;
  logic [R_W-1:0]    tm_r;
  side_t             tm_side;
  logic              sq_v;
  logic [S_W-1:0]    sq_s;
  side_t             sq_side;
  logic              sc_v;
  logic [RES_W-1:0]  sc_res;
  logic              sc_flag;

  logic              skid_v_r, skid_v_nxt;
  logic [RES_W-1:0]  skid_res_r;
  logic              skid_flag_r;
  logic [RES_W-1:0]  res_sel;

  // Whole pipeline advances while the skid register is empty
  assign en        = !skid_v_r;
  assign in_tready = en;

  bje_lookup #(.NUM_BINS(NUM_BINS)) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_tvalid),
    .eta      (in_tdata[ETA_W-1:0]),
    .et       (in_tdata[ETA_W+ET_W-1:ETA_W]),
    .out_v    (lk_v),
    .out_e    (lk_e),
    .out_a    (lk_a),
    .out_b2   (lk_b2),
    .out_c2   (lk_c2),
    .out_side (lk_side)
  );

  bje_terms u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (lk_v),
    .e        (lk_e),
    .a        (lk_a),
    .b2       (lk_b2),
    .c2       (lk_c2),
    .in_side  (lk_side),
    .out_v    (tm_v),
    .r        (tm_r),
    .out_side (tm_side)
  );

  bje_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (tm_v),
    .in_r     (tm_r),
    .in_side  (tm_side),
    .out_v    (sq_v),
    .s        (sq_s),
    .out_side (sq_side)
  );

  bje_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sq_v),
    .s        (sq_s),
    .in_side  (sq_side),
    .out_v    (sc_v),
    .res      (sc_res),
    .in_range (sc_flag)
  );

  // Skid register: catches the last-stage result when the receiver stalls
  always_comb begin
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_tready) skid_v_nxt = 1'b0;
    end else if (sc_v && !out_tready) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_res_r  <= sc_res;
      skid_flag_r <= sc_flag;
    end
  end

  // Output mux
  assign res_sel      = skid_v_r ? skid_res_r : sc_res;
  assign out_tvalid   = skid_v_r | sc_v;
  assign out_tdata    = {{(24-RES_W){1'b0}}, res_sel};
  assign out_tuser[0] = skid_v_r ? skid_flag_r : sc_flag;

  // Checks
  a_default_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[RES_W-1:0] == DEFAULT_RES)
    else $error("out-of-range jet without default resolution");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_v_r && sc_v && !out_tready |=> skid_v_r && out_tvalid)
    else $error("stalled result not captured by skid register");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> $stable(sc_v) && $stable(sc_res))
    else $error("pipeline moved while skid register was full");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for binned_jet_energy_resolution: streams jets in, checks every result.
// Depends on bje_pkg for field widths and on the RTL of the block; needs no other file.
module tb_top;
  import bje_pkg::*;

  localparam int N_BINS      = 26;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  // Expected content of one result request
  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             in_range;
  } jet_res_t;

  // Per-bin constants: upper edge (milli eta), a (1e-4), b and c (0.01), cosh(centre) in Q16
  typedef struct {
    longint unsigned hi;
    longint unsigned a;
    longint unsigned b;
    longint unsigned c;
    longint unsigned k;
  } bin_coef_t;

  // Predicts the resolution of each accepted jet and matches results in order
  class res_scoreboard;
    jet_res_t pending_q[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bin_coef_t bin_coef(int idx);
      bin_coef_t t;
      case (idx)
        0:  t = '{87,   686, 103, 168, 65598};
        1:  t = '{174,  737, 101, 174, 66095};
        2:  t = '{261,  657, 107, 0,   67092};
        3:  t = '{348,  620, 107, 0,   68598};
        4:  t = '{435,  605, 107, 0,   70623};
        5:  t = '{522,  590, 108, 0,   73183};
        6:  t = '{609,  577, 108, 0,   76297};
        7:  t = '{696,  525, 109, 0,   79989};
        8:  t = '{783,  582, 109, 0,   84287};
        9:  t = '{870,  649, 108, 0,   89223};
        10: t = '{957,  654, 110, 0,   94836};
        11: t = '{1044, 669, 111, 0,   101166};
        12: t = '{1131, 643, 115, 0,   108262};
        13: t = '{1218, 645, 116, 0,   116179};
        14: t = '{1305, 637, 119, 0,   124975};
        15: t = '{1392, 695, 121, 0,   134718};
        16: t = '{1479, 748, 120, 0,   145481};
        17: t = '{1566, 624, 123, 0,   157347};
        18: t = '{1653, 283, 125, 0,   170403};
        19: t = '{1740, 316, 121, 0,   184751};
        20: t = '{1830, 0,   120, 0,   200782};
        21: t = '{1930, 0,   114, 170, 219745};
        22: t = '{2043, 0,   109, 208, 243373};
        23: t = '{2172, 0,   109, 163, 273586};
        24: t = '{2322, 0,   109, 168, 313427};
        default: t = '{2500, 0, 112, 178, 368143};
      endcase
      return t;
    endfunction

    // floor(sqrt(x)), one root bit per step from the top
    static function longint unsigned floor_root(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    static function jet_res_t resolution_of(logic [ETA_W-1:0] eta, logic [ET_W-1:0] et);
      jet_res_t        r;
      bin_coef_t       bc;
      int              mag;
      int              nb;
      int              hit;
      longint unsigned e;
      longint unsigned ae;
      longint unsigned sq;
      longint unsigned q;
      mag = $signed(eta);
      if (mag < 0) mag = -mag;
      nb  = (N_BINS < 26) ? N_BINS : 26;
      hit = -1;
      for (int i = 0; i < nb; i++) begin
        bc = bin_coef(i);
        if (hit < 0 && longint'(mag) < longint'(bc.hi)) hit = i;
      end
      r.res      = 20'd1000;
      r.in_range = 1'b0;
      if (hit >= 0) begin
        bc = bin_coef(hit);
        e  = et;
        ae = bc.a * e;
        // 1e8 times the squared resolution in centi-GeV
        sq = ae * ae + 64'd1000000 * bc.b * bc.b * e + 64'd100000000 * bc.c * bc.c;
        q  = (floor_root(sq) * bc.k + 64'd327680000) / 64'd655360000;
        if (q > 64'd1048575) q = 64'd1048575;
        r.res      = q[RES_W-1:0];
        r.in_range = 1'b1;
      end
      return r;
    endfunction

    function void note_jet(logic [ETA_W-1:0] eta, logic [ET_W-1:0] et);
      pending_q = {pending_q, resolution_of(eta, et)};
    endfunction

    function void check_result(logic [RES_W-1:0] res, logic in_range);
      jet_res_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: res=%0d flag=%0d", res, in_range);
        return;
      end
      want = pending_q.pop_front();
      if (want.res !== res || want.in_range !== in_range) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result mismatch: expected res=%0d flag=%0d, got res=%0d flag=%0d",
                   want.res, want.in_range, res, in_range);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [13:0] eta_milli, [33:14] et_centi_gev, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [19:0] resolution_centi_gev, rest zero
  logic [0:0]  out_tuser;  // [0] in_bin_range

  res_scoreboard sb = new();
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  logic          hold_req = 1'b0;
  int            cycle_count = 0;

  binned_jet_energy_resolution #(.NUM_BINS(N_BINS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels; values read here are the ones present at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_jet(in_tdata[13:0], in_tdata[33:14]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata[19:0], out_tuser[0]);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one jet request, idling first at the current rate; returns at the accepting edge
  task automatic send_jet(input logic [ETA_W-1:0] eta, input logic [ET_W-1:0] et);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, et, eta};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every predicted result has come back;
  // a clock edge passes first so the last accepted request is already noted
  task automatic wait_empty();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ETA_W-1:0] pick_eta();
    int        mag;
    int        sel;
    bin_coef_t bc_pick;
    sel = $urandom_range(9);
    if (sel <= 5) begin
      mag = $urandom_range(2499);
    end else if (sel == 6) begin
      // straddle a bin edge
      bc_pick = res_scoreboard::bin_coef(int'($urandom_range(25)));
      mag     = int'(bc_pick.hi) - int'($urandom_range(1));
    end else if (sel == 7) begin
      return ETA_W'($urandom);
    end else if (sel == 8) begin
      mag = $urandom_range(2510, 2490);
    end else begin
      case ($urandom_range(2))
        0:       mag = 0;
        1:       mag = 8191;
        default: return 14'h2000;
      endcase
    end
    return $urandom_range(1) ? ETA_W'(-mag) : ETA_W'(mag);
  endfunction

  function automatic logic [ET_W-1:0] pick_et();
    case ($urandom_range(5))
      0, 1:    return ET_W'($urandom);
      2:       return ET_W'($urandom_range(5000));
      3:       return ET_W'($urandom_range(255));
      4:       return $urandom_range(1) ? '1 : '0;
      default: return ET_W'($urandom) >> $urandom_range(19);
    endcase
  endfunction

  task automatic random_jets(input int n);
    for (int i = 0; i < n; i++) send_jet(pick_eta(), pick_et());
  endtask

  task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    random_jets(n);
    wait_empty();
  endtask

  // Edges of the fields, bin boundaries, zero energy, default range, most negative eta
  task automatic directed_jets();
    int d_eta[24] = '{0, 0, 86, 87, -87, 260, 261, 1829, 1830, -1830, 2499, -2499,
                      2500, -2500, 8191, -8192, -8191, 1739, 1740, 1478, -1, 1, 2322, 2321};
    int d_et[24]  = '{0, 1048575, 1, 0, 12345, 0, 500, 0, 0, 1048575, 1048575, 0,
                      1048575, 1048575, 777, 1048575, 0, 1048575, 1048575, 1048575,
                      1, 524288, 2, 100000};
    for (int i = 0; i < 24; i++) send_jet(ETA_W'(d_eta[i]), ET_W'(d_et[i]));
    wait_empty();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_jets();

    // Full rate, with a long receiver hold-off that backs up the pipeline
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_jets(120);
    hold_req = 1'b1;
    random_jets(120);
    wait_empty();
    random_jets(120);
    wait_empty();

    run_phase(355, 66, 0);
    run_phase(355, 0, 66);
    run_phase(355, 32, 32);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
